@@ hdl/rec_pkg.sv @@
// Shared constants, codes and reset values for the route edge cost scorer.
// No dependencies.
`timescale 1ns / 1ps
package rec_pkg;

   localparam int DEF_COORD_BITS = 24;
   localparam int DEF_COST_BITS  = 48;

   localparam int SLOPE_BITS    = 24;   // Q8.16 slope
   localparam int FRAC_BITS     = 16;
   localparam int PEN_BITS      = 32;   // Q16.16 penalties
   localparam int BLOCK_BITS    = 48;   // Q32.16 blocking cost
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 48;
   localparam int SUM_BITS      = 66;   // holds any two clamped addends

   localparam logic [CSR_IDX_BITS-1:0] CSR_SLOPE_LIMIT   = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SLOPE_SCALE   = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_STAIR_PEN     = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_TRANSIT_PEN   = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_STEEP_PEN     = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_BLOCKED_COST  = 3'd5;

   localparam logic [1:0] STATUS_OPEN      = 2'd0;
   localparam logic [1:0] KIND_NORMAL      = 2'd0;
   localparam logic [1:0] KIND_STAIR       = 2'd1;
   localparam logic [1:0] KIND_TRANSIT     = 2'd2;
   localparam logic [1:0] KIND_STEEP       = 2'd3;
   localparam logic [1:0] REASON_NONE      = 2'd0;
   localparam logic [1:0] REASON_CLOSED    = 2'd1;
   localparam logic [1:0] REASON_FORBIDDEN = 2'd2;

   localparam logic [SLOPE_BITS-1:0] RST_SLOPE_LIMIT  = 24'd655360;
   localparam logic [SLOPE_BITS-1:0] RST_SLOPE_SCALE  = 24'd65536;
   localparam logic [PEN_BITS-1:0]   RST_STAIR_PEN    = 32'd131072;
   localparam logic [PEN_BITS-1:0]   RST_TRANSIT_PEN  = 32'd65536;
   localparam logic [PEN_BITS-1:0]   RST_STEEP_PEN    = 32'd196608;
   localparam logic [BLOCK_BITS-1:0] RST_BLOCKED_COST = 48'd65536000000;

endpackage

@@ hdl/rec_slope_cell.sv @@
// One cell of the slope search chain: settles one quotient bit per word.
// Depends on rec_pkg.
`timescale 1ns / 1ps
module rec_slope_cell
   import rec_pkg::*;
#(
   parameter int EW      = 98,
   parameter int BIT_POS = 0,
   parameter int SIDE_W  = 51
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  logic                  in_valid,
   input  logic [EW-1:0]         in_d,     // dx^2 + dy^2
   input  logic [EW-1:0]         in_e,     // remainder R - q^2 * D
   input  logic [EW-1:0]         in_p,     // q * D
   input  logic [SLOPE_BITS-1:0] in_q,
   input  logic [SIDE_W-1:0]     in_side,
   output logic                  out_valid,
   output logic [EW-1:0]         out_d,
   output logic [EW-1:0]         out_e,
   output logic [EW-1:0]         out_p,
   output logic [SLOPE_BITS-1:0] out_q,
   output logic [SIDE_W-1:0]     out_side
);

   logic                  valid_ff;
   logic [EW-1:0]         d_ff, e_ff, p_ff, e_in, p_in, trial;
   logic [SLOPE_BITS-1:0] q_ff, q_in;
   logic [SIDE_W-1:0]     side_ff;
   logic                  take;

   // (q + 2^b)^2 D - q^2 D = 2^(b+1) q D + 2^(2b) D
   always_comb begin
      trial = (in_p << (BIT_POS + 1)) + (in_d << (2 * BIT_POS));
      take  = (in_e >= trial);
      e_in  = take ? (in_e - trial) : in_e;
      p_in  = take ? (in_p + (in_d << BIT_POS)) : in_p;
      q_in  = in_q | (take ? (SLOPE_BITS'(1) << BIT_POS) : '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d_ff    <= in_d;
         e_ff    <= e_in;
         p_ff    <= p_in;
         q_ff    <= q_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_d     = d_ff;
   assign out_e     = e_ff;
   assign out_p     = p_ff;
   assign out_q     = q_ff;
   assign out_side  = side_ff;

endmodule

@@ hdl/route_edge_cost_scorer.sv @@
// Top level of the route edge cost scorer: input stages, slope cell chain, cost tail.
// Depends on rec_pkg and rec_slope_cell.
`timescale 1ns / 1ps
// Scores one route-graph edge per word and returns one result word per edge,
// in order. Throughput is one edge per clock while the result side does not
// stall; the 24 slope cells (one quotient bit each) sit behind three front stages
// (delta, square, distance) and ahead of two tail stages (scale multiply, final add).
// The whole pipe advances whenever the result register is empty or being taken,
// so a held result stalls every stage at once. Closed or forbidden edges give
// usable 0, all-ones cost and a reason; open edges give the saturated sum of
// base, penalty, risk, slope term and scene penalty, never all ones. Registers
// are written through the csr port; the user must write them only while the
// block is idle, which the block itself does not enforce; csr_ready is always high.
module route_edge_cost_scorer
   import rec_pkg::*;
#(
   parameter int COORD_BITS = DEF_COORD_BITS,
   parameter int COST_BITS  = DEF_COST_BITS
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // base_cost, extra_penalty, risk_cost, start_x, start_y, start_z,
   // end_x, end_y, end_z (low to high), zero fill to bytes
   input  logic [((COST_BITS+2*PEN_BITS+6*COORD_BITS+7)/8)*8-1:0] req_tdata,
   // edge_status, edge_kind (low to high)
   input  logic [3:0] req_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // total_cost, zero fill to bytes
   output logic [((COST_BITS+7)/8)*8-1:0] rsp_tdata,
   // usable, block_reason (low to high)
   output logic [2:0] rsp_tuser,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_data
);

   localparam int CB      = COORD_BITS;
   localparam int EW      = 2 * COORD_BITS + 50;
   localparam int SIDE_W  = COST_BITS + 3;
   localparam int NCELL   = SLOPE_BITS;
   localparam int OFF_EX  = COST_BITS;
   localparam int OFF_RK  = COST_BITS + PEN_BITS;
   localparam int OFF_CO  = COST_BITS + 2 * PEN_BITS;
   localparam int RSP_W   = ((COST_BITS + 7) / 8) * 8;
   localparam logic [COST_BITS-1:0] COST_MAX = '1;

   // configuration registers
   logic [SLOPE_BITS-1:0] slope_limit_ff, slope_scale_ff;
   logic [PEN_BITS-1:0]   stair_pen_ff, transit_pen_ff, steep_pen_ff;
   logic [BLOCK_BITS-1:0] blocked_cost_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         slope_limit_ff  <= RST_SLOPE_LIMIT;
         slope_scale_ff  <= RST_SLOPE_SCALE;
         stair_pen_ff    <= RST_STAIR_PEN;
         transit_pen_ff  <= RST_TRANSIT_PEN;
         steep_pen_ff    <= RST_STEEP_PEN;
         blocked_cost_ff <= RST_BLOCKED_COST;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_SLOPE_LIMIT:  slope_limit_ff  <= csr_data[SLOPE_BITS-1:0];
            CSR_SLOPE_SCALE:  slope_scale_ff  <= csr_data[SLOPE_BITS-1:0];
            CSR_STAIR_PEN:    stair_pen_ff    <= csr_data[PEN_BITS-1:0];
            CSR_TRANSIT_PEN:  transit_pen_ff  <= csr_data[PEN_BITS-1:0];
            CSR_STEEP_PEN:    steep_pen_ff    <= csr_data[PEN_BITS-1:0];
            CSR_BLOCKED_COST: blocked_cost_ff <= csr_data[BLOCK_BITS-1:0];
            default: ;   // drop writes beyond the register list
         endcase
      end
   end

   // whole pipe moves when the result register is free or being drained
   logic adv;
   logic out_valid_ff;
   assign adv        = !out_valid_ff || rsp_tready;
   assign req_tready = adv;

   // ---------------- stage 0: deltas, partial sums, status ----------------
   logic [CB-1:0] sx, sy, sz, ex, ey, ez;
   logic signed [CB:0] ddx, ddy, ddz;
   logic [CB:0] adx, ady, adz;
   logic [PEN_BITS-1:0] scene;
   logic [1:0] status, kind;

   assign sx     = req_tdata[OFF_CO + 0*CB +: CB];
   assign sy     = req_tdata[OFF_CO + 1*CB +: CB];
   assign sz     = req_tdata[OFF_CO + 2*CB +: CB];
   assign ex     = req_tdata[OFF_CO + 3*CB +: CB];
   assign ey     = req_tdata[OFF_CO + 4*CB +: CB];
   assign ez     = req_tdata[OFF_CO + 5*CB +: CB];
   assign status = req_tuser[1:0];
   assign kind   = req_tuser[3:2];

   always_comb begin
      ddx = $signed({sx[CB-1], sx}) - $signed({ex[CB-1], ex});
      ddy = $signed({sy[CB-1], sy}) - $signed({ey[CB-1], ey});
      ddz = $signed({sz[CB-1], sz}) - $signed({ez[CB-1], ez});
      adx = ddx[CB] ? (CB+1)'(-ddx) : (CB+1)'(ddx);
      ady = ddy[CB] ? (CB+1)'(-ddy) : (CB+1)'(ddy);
      adz = ddz[CB] ? (CB+1)'(-ddz) : (CB+1)'(ddz);
      unique case (kind)
         KIND_STAIR:   scene = stair_pen_ff;
         KIND_TRANSIT: scene = transit_pen_ff;
         KIND_STEEP:   scene = steep_pen_ff;
         default:      scene = '0;   // normal edge
      endcase
   end

   logic                 s0_valid_ff, s0_usable_ff;
   logic [1:0]           s0_reason_ff;
   logic [CB-1:0]        s0_dx_ff, s0_dy_ff, s0_dz_ff;
   logic [COST_BITS:0]   s0_a_ff;
   logic [PEN_BITS:0]    s0_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (adv) begin
         s0_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_dx_ff     <= adx[CB-1:0];
         s0_dy_ff     <= ady[CB-1:0];
         s0_dz_ff     <= adz[CB-1:0];
         s0_a_ff      <= {1'b0, req_tdata[COST_BITS-1:0]}
                         + (COST_BITS+1)'(req_tdata[OFF_EX +: PEN_BITS]);
         s0_b_ff      <= {1'b0, req_tdata[OFF_RK +: PEN_BITS]} + {1'b0, scene};
         s0_usable_ff <= (status == STATUS_OPEN);
         // unused status code counts as closed
         s0_reason_ff <= (status == STATUS_OPEN) ? REASON_NONE :
                         (status[0] ? REASON_CLOSED : REASON_FORBIDDEN);
      end
   end

   // ---------------- stage 1: squares, clamp base + penalties ----------------
   logic [SUM_BITS-1:0]  ab_sum;
   logic [COST_BITS-1:0] ab_clamp;

   always_comb begin
      ab_sum   = SUM_BITS'(s0_a_ff) + SUM_BITS'(s0_b_ff);
      ab_clamp = (ab_sum > SUM_BITS'(COST_MAX)) ? COST_MAX : ab_sum[COST_BITS-1:0];
   end

   logic                 s1_valid_ff;
   logic [2*CB-1:0]      s1_dx2_ff, s1_dy2_ff, s1_dz2_ff;
   logic [SIDE_W-1:0]    s1_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= s0_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_dx2_ff  <= (2*CB)'(s0_dx_ff) * (2*CB)'(s0_dx_ff);
         s1_dy2_ff  <= (2*CB)'(s0_dy_ff) * (2*CB)'(s0_dy_ff);
         s1_dz2_ff  <= (2*CB)'(s0_dz_ff) * (2*CB)'(s0_dz_ff);
         s1_side_ff <= {s0_reason_ff, s0_usable_ff, ab_clamp};
      end
   end

   // ---------------- stage 2: squared distance, scaled numerator ----------------
   logic [2*CB:0] dist2;

   always_comb begin
      dist2 = {1'b0, s1_dx2_ff} + {1'b0, s1_dy2_ff};
      // no horizontal move: take the distance as one millimetre
      if (dist2 == '0) begin
         dist2 = (2*CB+1)'(1);
      end
   end

   logic                 s2_valid_ff;
   logic [EW-1:0]        s2_d_ff, s2_e_ff;
   logic [SIDE_W-1:0]    s2_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_d_ff    <= EW'(dist2);
         s2_e_ff    <= EW'(s1_dz2_ff) << (2 * FRAC_BITS);
         s2_side_ff <= s1_side_ff;
      end
   end

   // ---------------- slope cells: largest q with q^2 D <= dz^2 2^32 ----------------
   logic                  ch_valid [0:NCELL];
   logic [EW-1:0]         ch_d     [0:NCELL];
   logic [EW-1:0]         ch_e     [0:NCELL];
   logic [EW-1:0]         ch_p     [0:NCELL];
   logic [SLOPE_BITS-1:0] ch_q     [0:NCELL];
   logic [SIDE_W-1:0]     ch_side  [0:NCELL];

   assign ch_valid[0] = s2_valid_ff;
   assign ch_d[0]     = s2_d_ff;
   assign ch_e[0]     = s2_e_ff;
   assign ch_p[0]     = '0;
   assign ch_q[0]     = '0;
   assign ch_side[0]  = s2_side_ff;

   for (genvar i = 0; i < NCELL; i++) begin : g_cell
      rec_slope_cell #(
         .EW      (EW),
         .BIT_POS (NCELL - 1 - i),
         .SIDE_W  (SIDE_W)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_valid  (ch_valid[i]),
         .in_d      (ch_d[i]),
         .in_e      (ch_e[i]),
         .in_p      (ch_p[i]),
         .in_q      (ch_q[i]),
         .in_side   (ch_side[i]),
         .out_valid (ch_valid[i+1]),
         .out_d     (ch_d[i+1]),
         .out_e     (ch_e[i+1]),
         .out_p     (ch_p[i+1]),
         .out_q     (ch_q[i+1]),
         .out_side  (ch_side[i+1])
      );
   end

   // ---------------- stage 3: slope times scale, limit check ----------------
   logic                       s3_valid_ff, s3_over_ff;
   logic [2*SLOPE_BITS-1:0]    s3_prod_ff;
   logic [SIDE_W-1:0]          s3_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (adv) begin
         s3_valid_ff <= ch_valid[NCELL];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_prod_ff <= (2*SLOPE_BITS)'(ch_q[NCELL]) * (2*SLOPE_BITS)'(slope_scale_ff);
         s3_over_ff <= (ch_q[NCELL] > slope_limit_ff);
         s3_side_ff <= ch_side[NCELL];
      end
   end

   // ---------------- stage 4: final sum into the result register ----------------
   logic [SUM_BITS-1:0]  slope_term, total_sum;
   logic [COST_BITS-1:0] total_cost;
   logic                 s3_usable;
   logic [1:0]           s3_reason;

   assign s3_usable = s3_side_ff[COST_BITS];
   assign s3_reason = s3_side_ff[COST_BITS+2 -: 2];

   always_comb begin
      slope_term = s3_over_ff ? SUM_BITS'(blocked_cost_ff)
                              : SUM_BITS'(s3_prod_ff >> FRAC_BITS);
      total_sum  = SUM_BITS'(s3_side_ff[COST_BITS-1:0]) + slope_term;
      // all ones is reserved for unusable edges
      if (!s3_usable) begin
         total_cost = COST_MAX;
      end else if (total_sum >= SUM_BITS'(COST_MAX)) begin
         total_cost = COST_MAX - COST_BITS'(1);
      end else begin
         total_cost = total_sum[COST_BITS-1:0];
      end
   end

   logic [COST_BITS-1:0] out_cost_ff;
   logic                 out_usable_ff;
   logic [1:0]           out_reason_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_cost_ff   <= total_cost;
         out_usable_ff <= s3_usable;
         out_reason_ff <= s3_reason;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_W'(out_cost_ff);
   assign rsp_tuser  = {out_reason_ff, out_usable_ff};

endmodule

@@ hdl/rec_checker.sv @@
// Port-level checks for the route edge cost scorer, bound to the top level.
// Depends on rec_pkg and route_edge_cost_scorer.
`timescale 1ns / 1ps
module rec_checker
   import rec_pkg::*;
#(
   parameter int COST_BITS = DEF_COST_BITS
) (
   input logic clock,
   input logic reset,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic [((COST_BITS+7)/8)*8-1:0] rsp_tdata,
   input logic [2:0] rsp_tuser
);

   // a stalled result word holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result word changed while stalled");

   // unusable edges carry infinite cost and a real reason
   a_unusable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |->
         (&rsp_tdata[COST_BITS-1:0]) &&
         (rsp_tuser[2:1] == REASON_CLOSED || rsp_tuser[2:1] == REASON_FORBIDDEN))
      else $error("unusable edge without infinite cost or reason");

   // usable edges never report infinite cost and carry no reason
   a_usable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |->
         !(&rsp_tdata[COST_BITS-1:0]) && rsp_tuser[2:1] == REASON_NONE)
      else $error("usable edge with infinite cost or reason");

endmodule

bind route_edge_cost_scorer rec_checker #(.COST_BITS(COST_BITS)) u_rec_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

@@ dv/tb_top.sv @@
// Self-checking testbench for route_edge_cost_scorer: directed edge table, then random edges.
// Depends on rec_pkg and the scorer RTL; predicts every untyped score with its own fixed-point model.
`timescale 1ns / 1ps
module tb_top;
   import rec_pkg::*;

   localparam logic [47:0] COST_ALL_ONES = 48'hFFFF_FFFF_FFFF;
   localparam int          DRAIN_CYCLES  = 40;   // pipe is 29 deep

   typedef struct {
      logic [1:0]         status;
      logic [1:0]         kind;
      logic [47:0]        base;
      logic [31:0]        extra;
      logic [31:0]        risk;
      logic signed [23:0] sx, sy, sz, ex, ey, ez;
   } edge_type;

   typedef struct {
      logic        usable;
      logic [47:0] cost;
      logic [1:0]  reason;
   } score_type;

   typedef struct {
      edge_type  e;
      bit        typed;      // expected score written in the row
      score_type r;
   } edge_row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [255:0] req_tdata = '0;
   logic [3:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b1;
   logic [47:0]  rsp_tdata;
   logic [2:0]   rsp_tuser;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [CSR_IDX_BITS-1:0]  csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_data = '0;

   // shadow copy of the scorer registers
   logic [23:0] slope_limit_r, slope_scale_r;
   logic [31:0] stair_pen_r, transit_pen_r, steep_pen_r;
   logic [47:0] blocked_cost_r;

   score_type pending_scores[$];
   bit        quiet = 1'b0;    // no idling on either side
   bit        failed = 1'b0;

   route_edge_cost_scorer dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("route_edge_cost_scorer test failed");
      $finish;
   end

   // ---------------------------------------------------------------- predictor
   function automatic logic [24:0] coord_gap(logic [23:0] a, logic [23:0] b);
      logic signed [24:0] d;
      d = $signed({a[23], a}) - $signed({b[23], b});
      return d[24] ? 25'(-d) : 25'(d);
   endfunction

   // largest q with q^2 (dx^2 + dy^2) <= (65536 dz)^2, 24 quotient bits
   function automatic logic [23:0] edge_slope(logic [24:0] dx, logic [24:0] dy,
                                              logic [24:0] dz);
      logic [127:0] lim, tx, ty;
      logic [23:0]  q, t;
      q = '0;
      if (dx == 0 && dy == 0) dx = 25'd1;
      lim = 128'(dz) * 128'(dz);
      lim = lim << 32;
      for (int b = 23; b >= 0; b--) begin
         t  = q | (24'd1 << b);
         tx = 128'(t) * 128'(dx);
         ty = 128'(t) * 128'(dy);
         if (tx * tx + ty * ty <= lim) q = t;
      end
      return q;
   endfunction

   function automatic logic [47:0] cost_add(logic [47:0] a, logic [47:0] b);
      logic [48:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[48] ? COST_ALL_ONES : s[47:0];
   endfunction

   function automatic score_type score_edge(edge_type e);
      score_type   r;
      logic [23:0] slope;
      logic [47:0] term, scene, sum;
      logic [47:0] prod;
      if (e.status != STATUS_OPEN) begin
         r.usable = 1'b0;
         r.cost   = COST_ALL_ONES;
         r.reason = e.status[0] ? REASON_CLOSED : REASON_FORBIDDEN;
         return r;
      end
      slope = edge_slope(coord_gap(e.sx, e.ex), coord_gap(e.sy, e.ey),
                         coord_gap(e.sz, e.ez));
      if (slope > slope_limit_r) term = blocked_cost_r;
      else begin
         prod = 48'(slope) * 48'(slope_scale_r);
         term = prod >> FRAC_BITS;
      end
      case (e.kind)
         KIND_STAIR:   scene = 48'(stair_pen_r);
         KIND_TRANSIT: scene = 48'(transit_pen_r);
         KIND_STEEP:   scene = 48'(steep_pen_r);
         default:      scene = '0;
      endcase
      sum = cost_add(e.base, 48'(e.extra));
      sum = cost_add(sum, 48'(e.risk));
      sum = cost_add(sum, term);
      sum = cost_add(sum, scene);
      if (sum == COST_ALL_ONES) sum = COST_ALL_ONES - 1;
      r.usable = 1'b1;
      r.cost   = sum;
      r.reason = REASON_NONE;
      return r;
   endfunction

   // ---------------------------------------------------------------- drivers
   task automatic write_reg(logic [CSR_IDX_BITS-1:0] idx, logic [47:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_SLOPE_LIMIT:  slope_limit_r  = value[23:0];
         CSR_SLOPE_SCALE:  slope_scale_r  = value[23:0];
         CSR_STAIR_PEN:    stair_pen_r    = value[31:0];
         CSR_TRANSIT_PEN:  transit_pen_r  = value[31:0];
         CSR_STEEP_PEN:    steep_pen_r    = value[31:0];
         CSR_BLOCKED_COST: blocked_cost_r = value;
         default: ;
      endcase
      @(negedge clock);
   endtask

   // hold the word until taken, then queue its expected score
   task automatic send_edge(edge_type e, score_type r);
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= {e.kind, e.status};
      req_tdata  <= {e.ez, e.ey, e.ex, e.sz, e.sy, e.sx, e.risk, e.extra, e.base};
      do @(posedge clock); while (!req_tready);
      pending_scores.push_back(r);
      @(negedge clock);
   endtask

   task automatic drain;
      while (pending_scores.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   // random coordinate; near_start keeps the gap small so slopes land near the limit
   function automatic logic [23:0] pick_coord(logic [23:0] from, bit near_start);
      int v;
      if (!near_start) return 24'($urandom);
      v = $signed(from) + $signed($urandom_range(0, 4000)) - 2000;
      if (v > 8388607 || v < -8388608) v = $signed(from);
      return 24'(v);
   endfunction

   function automatic edge_type random_edge();
      edge_type e;
      bit       near;
      e.status = ($urandom_range(0, 9) == 0) ? 2'($urandom) : STATUS_OPEN;
      e.kind   = 2'($urandom);
      case ($urandom_range(0, 3))
         0:       e.base = {16'($urandom), 32'($urandom)};
         1:       e.base = COST_ALL_ONES - 48'($urandom_range(0, 1 << 20));
         default: e.base = 48'($urandom_range(0, 1 << 24));
      endcase
      e.extra = ($urandom_range(0, 3) == 0) ? 32'($urandom) : 32'($urandom_range(0, 1 << 18));
      e.risk  = ($urandom_range(0, 3) == 0) ? 32'($urandom) : 32'($urandom_range(0, 1 << 18));
      near = ($urandom_range(0, 3) != 0);
      e.sx = 24'($urandom);
      e.sy = 24'($urandom);
      e.sz = 24'($urandom);
      e.ex = pick_coord(e.sx, near);
      e.ey = pick_coord(e.sy, near);
      e.ez = pick_coord(e.sz, near);
      if ($urandom_range(0, 15) == 0) begin
         e.ex = e.sx;   // vertical edge: distance floors to one millimetre
         e.ey = e.sy;
      end
      return e;
   endfunction

   // ---------------------------------------------------------------- checker
   always @(posedge clock) begin
      score_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_scores.size() == 0) begin
            $display("%t: unexpected result usable=%b cost=%h reason=%0d",
                     $time, rsp_tuser[0], rsp_tdata, rsp_tuser[2:1]);
            failed = 1'b1;
         end else begin
            want = pending_scores.pop_front();
            if (rsp_tuser[0] !== want.usable) begin
               $display("%t: usable expected %b actual %b", $time, want.usable, rsp_tuser[0]);
               failed = 1'b1;
            end
            if (rsp_tdata !== want.cost) begin
               $display("%t: total_cost expected %h actual %h", $time, want.cost, rsp_tdata);
               failed = 1'b1;
            end
            if (rsp_tuser[2:1] !== want.reason) begin
               $display("%t: block_reason expected %0d actual %0d",
                        $time, want.reason, rsp_tuser[2:1]);
               failed = 1'b1;
            end
         end
      end
   end

   // result-side stalls: random bursts until the quiet tail
   initial begin
      forever begin
         @(negedge clock);
         if (!quiet && $urandom_range(0, 9) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(0, 15)) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------- stimulus
   initial begin
      edge_row_type rows[16];
      edge_type     z, e;
      score_type    none, closed, forbid;
      logic [47:0]  regs[6];
      int           phase;

      slope_limit_r  = RST_SLOPE_LIMIT;
      slope_scale_r  = RST_SLOPE_SCALE;
      stair_pen_r    = RST_STAIR_PEN;
      transit_pen_r  = RST_TRANSIT_PEN;
      steep_pen_r    = RST_STEEP_PEN;
      blocked_cost_r = RST_BLOCKED_COST;

      z = '{STATUS_OPEN, KIND_NORMAL, 48'd0, 32'd0, 32'd0, 0, 0, 0, 0, 0, 0};
      none   = '{1'b0, 48'd0, REASON_NONE};
      closed = '{1'b0, COST_ALL_ONES, REASON_CLOSED};
      forbid = '{1'b0, COST_ALL_ONES, REASON_FORBIDDEN};
      foreach (rows[i]) rows[i] = '{z, 1'b0, none};

      // flat, zero edge under reset values: cost is the base alone
      rows[0].e.base = 48'd12345;
      rows[0].typed = 1'b1;  rows[0].r = '{1'b1, 48'd12345, REASON_NONE};
      rows[1].e.status = 2'd1;  rows[1].typed = 1'b1;  rows[1].r = closed;
      rows[2].e.status = 2'd2;  rows[2].typed = 1'b1;  rows[2].r = forbid;
      // unused status code counts as closed
      rows[3].e.status = 2'd3;  rows[3].typed = 1'b1;  rows[3].r = closed;
      // saturated sum reports all ones minus one
      rows[4].e.base = COST_ALL_ONES;  rows[4].e.extra = '1;  rows[4].e.risk = '1;
      rows[4].typed = 1'b1;  rows[4].r = '{1'b1, COST_ALL_ONES - 1, REASON_NONE};
      // vertical edge, full z swing: slope saturates, blocking cost applies
      rows[5].e.sz = -24'sd8388608;  rows[5].e.ez = 24'sd8388607;
      rows[5].typed = 1'b1;  rows[5].r = '{1'b1, RST_BLOCKED_COST, REASON_NONE};
      rows[6].e.kind = KIND_STAIR;    rows[6].typed = 1'b1;
      rows[6].r = '{1'b1, 48'(RST_STAIR_PEN), REASON_NONE};
      rows[7].e.kind = KIND_TRANSIT;  rows[7].typed = 1'b1;
      rows[7].r = '{1'b1, 48'(RST_TRANSIT_PEN), REASON_NONE};
      rows[8].e.kind = KIND_STEEP;    rows[8].typed = 1'b1;
      rows[8].r = '{1'b1, 48'(RST_STEEP_PEN), REASON_NONE};
      // corner to corner across the whole coordinate range
      rows[9].e  = '{STATUS_OPEN, KIND_STEEP, 48'd1, 32'hFFFF_FFFF, 32'd0,
                     -24'sd8388608, -24'sd8388608, -24'sd8388608,
                     24'sd8388607, 24'sd8388607, 24'sd8388607};
      // slope exactly at the limit: 1 m rise over 100 mm run
      rows[10].e.ex = 24'sd100;  rows[10].e.ez = 24'sd1000;
      rows[11].e.ex = 24'sd100;  rows[11].e.ez = 24'sd1001;   // just above
      rows[12].e.sy = 24'sd3;  rows[12].e.ex = 24'sd4;  rows[12].e.sz = 24'sd7;
      rows[13].e.risk = 32'hFFFF_FFFF;  rows[13].e.kind = KIND_STAIR;
      rows[13].e.sx = 24'sd8388607;  rows[13].e.ex = -24'sd8388608;
      rows[14].e.status = 2'd3;  rows[14].e.base = COST_ALL_ONES;  rows[14].e.kind = KIND_STEEP;
      rows[14].typed = 1'b1;  rows[14].r = closed;
      rows[15].e.ey = -24'sd1;  rows[15].e.ez = -24'sd10;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (rows[i]) send_edge(rows[i].e, rows[i].typed ? rows[i].r : score_edge(rows[i].e));
      req_tvalid <= 1'b0;
      drain();

      // register sets: extremes first, then random, then back to reset values
      for (phase = 0; phase < 8; phase++) begin
         case (phase)
            0: regs = '{48'd0, 48'd0, 48'd0, 48'd0, 48'd0, 48'd0};
            1: regs = '{48'hFF_FFFF, 48'hFF_FFFF, 48'hFFFF_FFFF, 48'hFFFF_FFFF,
                        48'hFFFF_FFFF, COST_ALL_ONES};
            2: regs = '{48'd0, 48'hFF_FFFF, 48'd0, 48'hFFFF_FFFF, 48'd0, COST_ALL_ONES};
            7: regs = '{48'(RST_SLOPE_LIMIT), 48'(RST_SLOPE_SCALE), 48'(RST_STAIR_PEN),
                        48'(RST_TRANSIT_PEN), 48'(RST_STEEP_PEN), RST_BLOCKED_COST};
            default:
               regs = '{48'($urandom_range(0, 24'hFF_FFFF)), 48'($urandom_range(0, 24'hFF_FFFF)),
                        48'($urandom), 48'($urandom), 48'($urandom),
                        {16'($urandom), 32'($urandom)}};
         endcase
         foreach (regs[i]) write_reg(CSR_IDX_BITS'(i), regs[i]);
         csr_valid <= 1'b0;
         if (phase == 7) quiet = 1'b1;
         repeat (210) begin
            e = random_edge();
            send_edge(e, score_edge(e));
         end
         req_tvalid <= 1'b0;
         drain();
      end

      if (!failed) begin
         $display("route_edge_cost_scorer test passed");
      end else begin
         $display("route_edge_cost_scorer test failed");
      end
      $finish;
   end

endmodule
